/* sv/clt_pkg.sv */
// clt_pkg: word types, operation codes and lease constants for the claim lease table
// used by clt_cfg, clt_row_update and claim_lease_table_unit; depends on nothing
`default_nettype none

package clt_pkg;

  localparam int LEASE_W    = 10;
  localparam int LEASE_MS_W = 20;
  localparam int PADDR_W    = 3;

  localparam logic [1:0] FUNC_EXTEND = 2'd0;
  localparam logic [1:0] FUNC_DROP   = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic REG_LEASE = 1'b0;

  localparam logic [LEASE_W-1:0]    LEASE_RESET_S     = 10'd90;
  localparam logic [LEASE_W-1:0]    LEASE_MIN_S       = 10'd30;
  localparam logic [LEASE_MS_W-1:0] MS_PER_S          = 20'd1000;
  localparam logic [LEASE_MS_W-1:0] LEASE_FALLBACK_MS = 20'd90000;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  node_id;
    logic [3:0]  owner_id;
    logic [31:0] now_ms;
  } clt_req_t;

  typedef struct packed {
    logic        live;
    logic [15:0] owner_mask;
  } clt_rsp_t;

  typedef struct packed {
    logic extend;
    logic drop;
    logic query;
  } clt_op_t;

endpackage

`default_nettype wire

/* sv/clt_ram.sv */
// clt_ram: generic single-write, single-read ram with registered read data
// no package dependency
`default_nettype none

module clt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/clt_cfg.sv */
// clt_cfg: apb register block holding lease_seconds and the derived lease in ms
// depends on clt_pkg
`default_nettype none

module clt_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [clt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic [clt_pkg::LEASE_MS_W-1:0]   lease_ms
);
  import clt_pkg::*;

  logic [LEASE_W-1:0]    lease_seconds;
  logic [LEASE_W-1:0]    wr_seconds;
  logic [LEASE_MS_W-1:0] lease_ms_next;
  logic                  wr_lease;

  assign pready     = 1'b1;
  assign wr_seconds = pwdata[LEASE_W-1:0];
  assign wr_lease   = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_LEASE);

  always_comb begin
    if (wr_seconds >= LEASE_MIN_S) begin
      lease_ms_next = LEASE_MS_W'(wr_seconds) * MS_PER_S;
    end else begin
      lease_ms_next = LEASE_FALLBACK_MS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lease_seconds <= LEASE_RESET_S;
      lease_ms      <= LEASE_FALLBACK_MS;
    end else if (wr_lease) begin
      lease_seconds <= wr_seconds;
      lease_ms      <= lease_ms_next;
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_LEASE) ? 32'(lease_seconds) : 32'd0;

endmodule

`default_nettype wire

/* sv/clt_row_update.sv */
// clt_row_update: new valid and expiry row of one node, and the query result
// depends on clt_pkg
`default_nettype none

module clt_row_update #(
  parameter int OWNERS = 16
) (
  input  clt_pkg::clt_op_t                  op,
  input  wire logic [3:0]                   owner_id,
  input  wire logic [31:0]                  now_ms,
  input  wire logic [clt_pkg::LEASE_MS_W-1:0] lease_ms,
  input  wire logic [OWNERS-1:0]            vrow_in,
  input  wire logic [OWNERS-1:0][31:0]      erow_in,
  output logic      [OWNERS-1:0]            vrow_new,
  output logic      [OWNERS-1:0][31:0]      erow_new,
  output logic      [OWNERS-1:0]            exp_we,
  output logic      [31:0]                  exp_new,
  output logic                              wr_row,
  output clt_pkg::clt_rsp_t                 rsp_next
);
  import clt_pkg::*;

  localparam int OWNER_AW = (OWNERS > 1) ? $clog2(OWNERS) : 1;

  logic [OWNER_AW-1:0] lane;
  logic [OWNERS-1:0]   sel;
  logic [OWNERS-1:0]   keep;
  logic [15:0]         keep16;

  genvar g;
  generate
    for (g = 0; g < 16; g++) begin : g_mask
      if (g < OWNERS) begin : g_have
        assign keep16[g] = keep[g];
      end else begin : g_none
        assign keep16[g] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    lane    = OWNER_AW'(owner_id);
    sel     = OWNERS'(1) << lane;
    exp_new = now_ms + 32'(lease_ms);
    wr_row  = op.extend || op.drop || op.query;
    exp_we  = op.extend ? sel : '0;

    for (int i = 0; i < OWNERS; i++) begin
      keep[i]     = vrow_in[i] && (now_ms < erow_in[i]);
      erow_new[i] = exp_we[i] ? exp_new : erow_in[i];
    end

    if (op.extend) begin
      vrow_new = vrow_in | sel;
    end else if (op.drop) begin
      vrow_new = vrow_in & ~sel;
    end else if (op.query) begin
      vrow_new = keep;
    end else begin
      vrow_new = vrow_in;
    end

    rsp_next = '0;
    if (op.query) begin
      rsp_next.live       = |keep;
      rsp_next.owner_mask = keep16;
    end
  end

endmodule

`default_nettype wire

/* sv/claim_lease_table_unit.sv */
// claim_lease_table_unit: lease table per node and owner with expiry on query
// depends on clt_pkg, clt_ram, clt_cfg, clt_row_update
//
//   channel | dir | handshake           | word
//   req     | in  | req_valid/req_ready | func, node_id, owner_id, now_ms
//   rsp     | out | rsp_valid/rsp_ready | live, owner_mask
//   apb     | in  | psel/penable/pready | lease_seconds at byte 0
//
// one word per cycle while rsp is not stalled; a result word passes the s1 stage register, then the rsp register
// the node row is read from the rams at acceptance, updated in stage s1 and written back as that stage advances
// a write to the same node at the edge that accepts a request is forwarded from a row register
// reset clears the per-node row flags, so all claims read as absent; no clearing pass
// a stalled rsp holds the stage register and stops req_ready once that stage is full
`default_nettype none

module claim_lease_table_unit #(
  parameter int NODES  = 16,
  parameter int OWNERS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  clt_pkg::clt_req_t                req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output clt_pkg::clt_rsp_t                rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [clt_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import clt_pkg::*;

  localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [LEASE_MS_W-1:0] lease_ms;

  logic                  req_fire;
  logic                  req_node_ok;
  logic                  req_owner_ok;
  logic [NODE_AW-1:0]    req_node;
  clt_op_t               req_op;

  logic                  s1_valid;
  logic                  s1_adv;
  clt_req_t              s1_q;
  clt_op_t               s1_op;
  logic                  s1_live;
  logic                  s1_byp;
  logic [NODE_AW-1:0]    s1_node;

  logic [NODES-1:0]        row_live;
  logic [OWNERS-1:0]       fwd_v;
  logic [OWNERS-1:0][31:0] fwd_e;
  logic [OWNERS-1:0]       ram_v;
  logic [OWNERS-1:0][31:0] ram_e;
  logic [OWNERS-1:0]       vrow_in;
  logic [OWNERS-1:0][31:0] erow_in;
  logic [OWNERS-1:0]       vrow_new;
  logic [OWNERS-1:0][31:0] erow_new;
  logic [OWNERS-1:0]       exp_we;
  logic [31:0]             exp_new;
  logic                    wr_row;
  clt_rsp_t                rsp_next;

  clt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .lease_ms (lease_ms)
  );

  // request decode
  always_comb begin
    req_node_ok   = 32'(req.node_id) < NODES;
    req_owner_ok  = 32'(req.owner_id) < OWNERS;
    req_node      = NODE_AW'(req.node_id);
    req_op.extend = req_node_ok && req_owner_ok && (req.func == FUNC_EXTEND);
    req_op.drop   = req_node_ok && req_owner_ok && (req.func == FUNC_DROP);
    req_op.query  = req_node_ok && (req.func == FUNC_QUERY);
  end

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;
  assign req_fire  = req_valid && req_ready;
  assign s1_node   = NODE_AW'(s1_q.node_id);

  clt_ram #(
    .WIDTH (OWNERS),
    .DEPTH (NODES)
  ) u_valid_ram (
    .clk   (clk),
    .we    (s1_adv && wr_row),
    .waddr (s1_node),
    .wdata (vrow_new),
    .re    (req_fire),
    .raddr (req_node),
    .rdata (ram_v)
  );

  genvar g;
  generate
    for (g = 0; g < OWNERS; g++) begin : g_lane
      clt_ram #(
        .WIDTH (32),
        .DEPTH (NODES)
      ) u_exp_ram (
        .clk   (clk),
        .we    (s1_adv && exp_we[g]),
        .waddr (s1_node),
        .wdata (exp_new),
        .re    (req_fire),
        .raddr (req_node),
        .rdata (ram_e[g])
      );
    end
  endgenerate

  assign vrow_in = s1_byp ? fwd_v : (s1_live ? ram_v : '0);
  assign erow_in = s1_byp ? fwd_e : ram_e;

  clt_row_update #(
    .OWNERS (OWNERS)
  ) u_row_update (
    .op       (s1_op),
    .owner_id (s1_q.owner_id),
    .now_ms   (s1_q.now_ms),
    .lease_ms (lease_ms),
    .vrow_in  (vrow_in),
    .erow_in  (erow_in),
    .vrow_new (vrow_new),
    .erow_new (erow_new),
    .exp_we   (exp_we),
    .exp_new  (exp_new),
    .wr_row   (wr_row),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      s1_byp    <= 1'b0;
      row_live  <= '0;
    end else begin
      if (req_fire) begin
        s1_valid <= 1'b1;
        s1_byp   <= s1_adv && wr_row && (s1_q.node_id == req.node_id);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (s1_adv && wr_row) begin
        row_live[s1_node] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_q    <= req;
      s1_op   <= req_op;
      s1_live <= req_node_ok && row_live[req_node];
      fwd_v   <= vrow_new;
      fwd_e   <= erow_new;
    end
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> rsp_valid && (rsp == $past(rsp_next)))
    else $error("stage result not registered");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_q) && $stable(s1_byp))
    else $error("stalled stage changed");

  a_live_mask: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (OWNERS <= 16) |-> rsp.live == (rsp.owner_mask != 16'd0))
    else $error("live flag disagrees with owner mask");

  a_range_write: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !(32'(s1_q.node_id) < NODES) |-> !wr_row)
    else $error("write to node out of range");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench for claim_lease_table_unit: directed and random lease traffic under random stalls
// needs clt_pkg and the claim_lease_table_unit rtl; every result is checked against a local table

class lease_scoreboard;
  bit                claim_on[256];
  logic [31:0]       expiry_ms[256];
  logic [9:0]        lease_s;
  clt_pkg::clt_rsp_t pending_reports[$];
  int                errors;

  function new();
    lease_s = clt_pkg::LEASE_RESET_S;
    errors = 0;
  endfunction

  function logic [31:0] lease_ms();
    if (lease_s >= clt_pkg::LEASE_MIN_S) begin
      return 32'(lease_s) * 32'(clt_pkg::MS_PER_S);
    end
    return 32'(clt_pkg::LEASE_FALLBACK_MS);
  endfunction

  function void note_request(clt_pkg::clt_req_t w);
    clt_pkg::clt_rsp_t r;
    int                row;
    r = '0;
    row = int'(w.node_id) * 16;
    case (w.func)
      clt_pkg::FUNC_EXTEND: begin
        expiry_ms[row + int'(w.owner_id)] = w.now_ms + lease_ms();
        claim_on[row + int'(w.owner_id)] = 1'b1;
      end
      clt_pkg::FUNC_DROP: begin
        claim_on[row + int'(w.owner_id)] = 1'b0;
      end
      clt_pkg::FUNC_QUERY: begin
        for (int i = 0; i < 16; i++) begin
          if (claim_on[row + i] && w.now_ms >= expiry_ms[row + i]) begin
            claim_on[row + i] = 1'b0;
          end
          if (claim_on[row + i]) begin
            r.live = 1'b1;
            r.owner_mask[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    pending_reports = {pending_reports, r};
  endfunction

  function void check_report(clt_pkg::clt_rsp_t got);
    clt_pkg::clt_rsp_t want;
    if (pending_reports.size() == 0) begin
      $error("unexpected result word: live %0d owner_mask %h", got.live, got.owner_mask);
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    if (got.live !== want.live) begin
      $error("live expected %0d got %0d", want.live, got.live);
      errors++;
    end
    if (got.owner_mask !== want.owner_mask) begin
      $error("owner_mask expected %h got %h", want.owner_mask, got.owner_mask);
      errors++;
    end
  endfunction
endclass

module testbench;
  import clt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED     = 2'd3;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         IDLE_LIMIT      = 3000;
  localparam int         PHASE_WORDS     = 260;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  clt_req_t           req;
  logic               rsp_valid;
  logic               rsp_ready;
  clt_rsp_t           rsp;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lease_scoreboard sb = new();
  bit              sender_idles = 1'b1;
  bit              receiver_stalls = 1'b1;
  int              hold_req_id = 0;
  int              idle_cycles = 0;
  logic [31:0]     clock_ms;

  claim_lease_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus the long hold-off on request
  initial begin
    int stall_left;
    int seen_hold;
    stall_left = 0;
    seen_hold = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req_id != seen_hold) begin
        seen_hold = hold_req_id;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_report(rsp);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic clt_req_t make_word(logic [1:0] f, int node, int owner, logic [31:0] now);
    clt_req_t w;
    w.func = f;
    w.node_id = 4'(node);
    w.owner_id = 4'(owner);
    w.now_ms = now;
    return w;
  endfunction

  // mostly a few busy nodes on an advancing clock, with jumps and random times as noise
  function automatic clt_req_t random_word();
    clt_req_t w;
    int       r;
    r = $urandom_range(0, 99);
    w.func = (r < 40) ? FUNC_EXTEND : (r < 55) ? FUNC_DROP : (r < 95) ? FUNC_QUERY : FUNC_UNUSED;
    w.node_id = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    w.owner_id = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 90) begin
      clock_ms = clock_ms + $urandom_range(0, 4000);
    end else if (r < 96) begin
      clock_ms = clock_ms + $urandom_range(0, 2000000);
    end
    w.now_ms = (r >= 98) ? $urandom : clock_ms;
    return w;
  endfunction

  task automatic send_word(clt_req_t w);
    int r;
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(w);
    r = $urandom_range(0, 99);
    gap = 0;
    if (sender_idles && r >= 55) begin
      gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'(4 * int'(REG_LEASE));
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr) begin
      sb.lease_s = wdata[LEASE_W-1:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_lease(logic [9:0] s);
    logic [31:0] back;
    apb_access(1'b1, {22'b0, s}, back);
    apb_access(1'b0, '0, back);
    if (back !== {22'b0, s}) begin
      $error("lease_seconds expected %0d got %0d", s, back);
      sb.errors++;
    end
  endtask

  initial begin
    logic [9:0] phase_lease[7];
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clock_ms = '0;
    phase_lease = '{10'd0, 10'd29, 10'd30, 10'd600, 10'd1023, 10'd0, 10'd31};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset lease of 90 s
    send_word(make_word(FUNC_QUERY, 0, 0, 32'd0));
    send_word(make_word(FUNC_EXTEND, 0, 0, 32'd0));
    send_word(make_word(FUNC_EXTEND, 0, 15, 32'd1000));
    send_word(make_word(FUNC_QUERY, 0, 3, 32'd50000));
    send_word(make_word(FUNC_QUERY, 0, 0, 32'd90000));
    send_word(make_word(FUNC_DROP, 0, 15, 32'd90001));
    send_word(make_word(FUNC_DROP, 0, 15, 32'd90002));
    send_word(make_word(FUNC_QUERY, 0, 0, 32'd90003));
    send_word(make_word(FUNC_UNUSED, 15, 15, 32'hFFFF_FFFF));
    send_word(make_word(FUNC_EXTEND, 15, 15, 32'hFFFF_FFFF));
    send_word(make_word(FUNC_QUERY, 15, 0, 32'hFFFF_FFFF));
    send_word(make_word(FUNC_EXTEND, 15, 7, 32'd100));
    send_word(make_word(FUNC_EXTEND, 15, 7, 32'd200000));
    send_word(make_word(FUNC_QUERY, 15, 7, 32'd150000));
    send_word(make_word(FUNC_EXTEND, 5, 0, 32'hAAAA_AAAA));
    send_word(make_word(FUNC_EXTEND, 5, 5, 32'h5555_5555));
    send_word(make_word(FUNC_QUERY, 5, 10, 32'h5555_5556));
    send_word(make_word(FUNC_EXTEND, 10, 10, 32'h0F0F_0F0F));
    send_word(make_word(FUNC_EXTEND, 10, 5, 32'hF0F0_F0F0));
    send_word(make_word(FUNC_QUERY, 10, 15, 32'hF0F0_F0F0));
    send_word(make_word(FUNC_UNUSED, 10, 5, 32'd0));
    send_word(make_word(FUNC_DROP, 10, 5, 32'd0));
    send_word(make_word(FUNC_QUERY, 10, 0, 32'd0));
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p == 5) begin
        phase_lease[p] = 10'($urandom_range(0, 1023));
      end
      set_lease(phase_lease[p]);
      sender_idles = (p % 3 != 1);
      receiver_stalls = (p % 3 != 2);
      // long lease across the 32-bit wrap
      if (p == 3) begin
        clock_ms = 32'hFFF8_0000;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 1 && k == 40) begin
          hold_req_id++;
        end
        send_word(random_word());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
